/* hdl/gou_pkg.sv */
// gou_pkg: shared types, constants and register codes of the gradient optimizer update core.
// Used by gou_csr, gou_front, gou_fifo, gou_back and the top level; depends on nothing.
package gou_pkg;

   localparam int DATA_W = 32;
   localparam int FRAC_W = 24;
   localparam int COEF_W = 16;
   localparam int LR_W   = 25;
   localparam int CORR_W = 33;
   localparam int IDX_W  = 3;
   localparam int ADDR_W = 5;
   localparam int FIFO_DEPTH = 4;

   localparam logic [1:0] MODE_SGD      = 2'd0;
   localparam logic [1:0] MODE_MOMENTUM = 2'd1;
   localparam logic [1:0] MODE_RMSPROP  = 2'd2;
   localparam logic [1:0] MODE_ADAM     = 2'd3;

   localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
   localparam logic [IDX_W-1:0] REG_LR       = 3'd1;
   localparam logic [IDX_W-1:0] REG_BETA1    = 3'd2;
   localparam logic [IDX_W-1:0] REG_BETA2    = 3'd3;
   localparam logic [IDX_W-1:0] REG_EPSILON  = 3'd4;
   localparam logic [IDX_W-1:0] REG_STEP_CNT = 3'd5;

   localparam logic [1:0]        RST_MODE  = MODE_SGD;
   localparam logic [LR_W-1:0]   RST_LR    = 25'd167772;
   localparam logic [COEF_W-1:0] RST_BETA1 = 16'd58982;
   localparam logic [COEF_W-1:0] RST_BETA2 = 16'd65470;
   localparam logic [COEF_W-1:0] RST_EPS   = 16'd1;
   localparam logic [COEF_W-1:0] RST_STEP  = 16'd1;

   localparam logic [DATA_W-1:0] SMAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] SMIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] UMAX = 32'hffff_ffff;

   typedef struct packed {
      logic [1:0]        mode;
      logic [LR_W-1:0]   lr;
      logic [COEF_W-1:0] beta1;
      logic [COEF_W-1:0] beta2;
      logic [COEF_W-1:0] eps;
      logic [CORR_W-1:0] corr1;   // 1 - beta1^t, Q1.32
      logic [CORR_W-1:0] corr2;   // 1 - beta2^t, Q1.32
   } cfg_type;

   // item handed from front to back
   typedef struct packed {
      logic [DATA_W-1:0] p;
      logic [DATA_W-1:0] g;
      logic [DATA_W-1:0] m;
      logic [DATA_W-1:0] v;
      logic [DATA_W-1:0] p01;     // finished parameter for SGD and momentum
      logic              flag;
   } fq_type;

endpackage

/* hdl/gou_csr.sv */
// gou_csr: APB register file and the bias correction sequencer (1 - beta^t).
// Depends on gou_pkg.
module gou_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gou_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output gou_pkg::cfg_type            cfg,
   output logic                        busy
);
   import gou_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_INIT = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;

   logic [1:0]        mode_ff, mode_in;
   logic [LR_W-1:0]   lr_ff, lr_in;
   logic [COEF_W-1:0] beta1_ff, beta1_in, beta2_ff, beta2_in, eps_ff, eps_in, step_ff, step_in;
   logic [1:0]        state_ff, state_in;
   logic [4:0]        cnt_ff, cnt_in;
   logic [32:0]       res1_ff, res1_in, res2_ff, res2_in;
   logic [31:0]       base1_ff, base1_in, base2_ff, base2_in;
   logic [CORR_W-1:0] corr1_ff, corr1_in, corr2_ff, corr2_in;

   logic              wr;
   logic [IDX_W-1:0]  idx;
   logic              restart;
   logic [COEF_W-1:0] tcnt;
   logic              phase, tbit;
   logic [32:0]       opa1, opa2;
   logic [64:0]       prod1, prod2;
   logic [32:0]       rnd1, rnd2;
   logic [32:0]       diff1, diff2;

   assign pready = 1'b1;
   assign wr     = psel & penable & pwrite;
   assign idx    = paddr[ADDR_W-1:2];

   always_comb begin
      mode_in  = mode_ff;
      lr_in    = lr_ff;
      beta1_in = beta1_ff;
      beta2_in = beta2_ff;
      eps_in   = eps_ff;
      step_in  = step_ff;
      restart  = 1'b0;
      if (wr) begin
         unique case (idx)
            REG_MODE:     mode_in  = pwdata[1:0];
            REG_LR:       lr_in    = pwdata[LR_W-1:0];
            REG_BETA1:    begin beta1_in = pwdata[COEF_W-1:0]; restart = 1'b1; end
            REG_BETA2:    begin beta2_in = pwdata[COEF_W-1:0]; restart = 1'b1; end
            REG_EPSILON:  eps_in   = pwdata[COEF_W-1:0];
            REG_STEP_CNT: begin step_in = pwdata[COEF_W-1:0]; restart = 1'b1; end
            default:      ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (idx)
         REG_MODE:     prdata = {30'd0, mode_ff};
         REG_LR:       prdata = {7'd0, lr_ff};
         REG_BETA1:    prdata = {16'd0, beta1_ff};
         REG_BETA2:    prdata = {16'd0, beta2_ff};
         REG_EPSILON:  prdata = {16'd0, eps_ff};
         REG_STEP_CNT: prdata = {16'd0, step_ff};
         default:      prdata = '0;
      endcase
   end

   // square and multiply, one product per beta per cycle; even count multiplies
   // into the result, odd count squares the base
   assign tcnt  = (step_ff == '0) ? 16'd1 : step_ff;
   assign phase = cnt_ff[0];
   assign tbit  = tcnt[cnt_ff[4:1]];
   assign opa1  = phase ? {1'b0, base1_ff} : res1_ff;
   assign opa2  = phase ? {1'b0, base2_ff} : res2_ff;
   assign prod1 = 65'(opa1) * 65'(base1_ff);
   assign prod2 = 65'(opa2) * 65'(base2_ff);
   assign rnd1  = 33'((prod1 + 65'h0_8000_0000) >> 32);
   assign rnd2  = 33'((prod2 + 65'h0_8000_0000) >> 32);
   assign diff1 = 33'h1_0000_0000 - res1_ff;
   assign diff2 = 33'h1_0000_0000 - res2_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      res1_in  = res1_ff;
      res2_in  = res2_ff;
      base1_in = base1_ff;
      base2_in = base2_ff;
      corr1_in = corr1_ff;
      corr2_in = corr2_ff;
      unique case (state_ff)
         ST_INIT: begin
            res1_in  = 33'h1_0000_0000;
            res2_in  = 33'h1_0000_0000;
            base1_in = {beta1_ff, 16'd0};
            base2_in = {beta2_ff, 16'd0};
            cnt_in   = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               corr1_in = (diff1 == '0) ? 33'd1 : diff1;
               corr2_in = (diff2 == '0) ? 33'd1 : diff2;
               state_in = ST_IDLE;
            end else if (phase) begin
               base1_in = rnd1[31:0];
               base2_in = rnd2[31:0];
            end else if (tbit) begin
               res1_in = rnd1;
               res2_in = rnd2;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (restart) state_in = ST_INIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= RST_MODE;
         lr_ff    <= RST_LR;
         beta1_ff <= RST_BETA1;
         beta2_ff <= RST_BETA2;
         eps_ff   <= RST_EPS;
         step_ff  <= RST_STEP;
         state_ff <= ST_INIT;
         cnt_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         lr_ff    <= lr_in;
         beta1_ff <= beta1_in;
         beta2_ff <= beta2_in;
         eps_ff   <= eps_in;
         step_ff  <= step_in;
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      res1_ff  <= res1_in;
      res2_ff  <= res2_in;
      base1_ff <= base1_in;
      base2_ff <= base2_in;
      corr1_ff <= corr1_in;
      corr2_ff <= corr2_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign cfg.mode  = mode_ff;
   assign cfg.lr    = lr_ff;
   assign cfg.beta1 = beta1_ff;
   assign cfg.beta2 = beta2_ff;
   assign cfg.eps   = eps_ff;
   assign cfg.corr1 = corr1_ff;
   assign cfg.corr2 = corr2_ff;

endmodule

/* hdl/gou_front.sv */
// gou_front: accepts items, updates the moments and finishes SGD / momentum steps.
// Three register stages feeding the queue; depends on gou_pkg.
module gou_front (
   input  logic                        clock,
   input  logic                        reset,
   input  gou_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [gou_pkg::DATA_W-1:0]  in_p,
   input  logic [gou_pkg::DATA_W-1:0]  in_g,
   input  logic [gou_pkg::DATA_W-1:0]  in_m,
   input  logic [gou_pkg::DATA_W-1:0]  in_v,
   output logic                        push,
   input  logic                        full,
   output gou_pkg::fq_type             out_item
);
   import gou_pkg::*;

   logic en;
   logic f1_vld_ff, f2_vld_ff, f3_vld_ff;

   // stage 1
   logic signed [48:0] f1_b1m_ff;
   logic signed [49:0] f1_c1g_ff;
   logic [63:0]        f1_gg_ff;
   logic [47:0]        f1_b2v_ff;
   logic [DATA_W-1:0]  f1_p_ff, f1_g_ff, f1_m_ff, f1_v_ff;
   logic [DATA_W-1:0]  ga;
   logic [16:0]        c1coef, c2coef;

   // stage 2
   logic [DATA_W-1:0]  f2_p_ff, f2_g_ff, f2_m_ff, f2_v_ff, f2_x_ff;
   logic [39:0]        f2_g2_ff;
   logic [32:0]        f2_t1_ff;
   logic               f2_fm_ff;
   logic signed [32:0] term_m;
   logic signed [33:0] term_g;
   logic signed [34:0] msum;
   logic [DATA_W-1:0]  m_new, m_sel, x_sel;
   logic               fm;
   logic [39:0]        g2;
   logic [32:0]        t1;

   // stage 3
   logic signed [57:0] f3_lrx_ff;
   logic [56:0]        f3_c2g2_ff;
   logic [DATA_W-1:0]  f3_p_ff, f3_g_ff, f3_m_ff, f3_v_ff;
   logic [32:0]        f3_t1_ff;
   logic               f3_fm_ff;

   // final combine
   logic signed [33:0] step;
   logic signed [34:0] pdiff;
   logic [41:0]        t2;
   logic [42:0]        vsum;
   logic [DATA_W-1:0]  p01, v_new;
   logic               fp, fv, slow_mode;

   assign en       = ~(f3_vld_ff & full);
   assign in_ready = en;
   assign push     = f3_vld_ff & ~full;

   assign ga     = in_g[DATA_W-1] ? (~in_g + 32'd1) : in_g;
   assign c1coef = 17'h1_0000 - {1'b0, cfg.beta1};
   assign c2coef = 17'h1_0000 - {1'b0, cfg.beta2};

   always_ff @(posedge clock) begin
      if (reset) f1_vld_ff <= 1'b0;
      else if (en) f1_vld_ff <= in_valid;
      if (en) begin
         f1_b1m_ff <= $signed({1'b0, cfg.beta1}) * $signed(in_m);
         f1_c1g_ff <= $signed({1'b0, c1coef}) * $signed(in_g);
         f1_gg_ff  <= 64'(ga) * 64'(ga);
         f1_b2v_ff <= 48'(cfg.beta2) * 48'(in_v);
         f1_p_ff   <= in_p;
         f1_g_ff   <= in_g;
         f1_m_ff   <= in_m;
         f1_v_ff   <= in_v;
      end
   end

   always_comb begin
      term_m = 33'((f1_b1m_ff + 49'sd32768) >>> 16);
      term_g = 34'((f1_c1g_ff + 50'sd32768) >>> 16);
      if (cfg.mode == MODE_MOMENTUM) msum = 35'(term_m) + 35'($signed(f1_g_ff));
      else                           msum = 35'(term_m) + 35'(term_g);
      fm = 1'b0;
      if (msum > 35'sd2147483647) begin
         m_new = SMAX;
         fm    = 1'b1;
      end else if (msum < -35'sd2147483648) begin
         m_new = SMIN;
         fm    = 1'b1;
      end else begin
         m_new = msum[DATA_W-1:0];
      end
      if (cfg.mode == MODE_MOMENTUM || cfg.mode == MODE_ADAM) begin
         m_sel = m_new;
      end else begin
         m_sel = f1_m_ff;
         fm    = 1'b0;
      end
      x_sel = (cfg.mode == MODE_MOMENTUM) ? m_new : f1_g_ff;
      g2    = 40'((f1_gg_ff + 64'h80_0000) >> FRAC_W);
      t1    = 33'((49'(f1_b2v_ff) + 49'd32768) >> 16);
   end

   always_ff @(posedge clock) begin
      if (reset) f2_vld_ff <= 1'b0;
      else if (en) f2_vld_ff <= f1_vld_ff;
      if (en) begin
         f2_p_ff  <= f1_p_ff;
         f2_g_ff  <= f1_g_ff;
         f2_m_ff  <= m_sel;
         f2_v_ff  <= f1_v_ff;
         f2_x_ff  <= x_sel;
         f2_g2_ff <= g2;
         f2_t1_ff <= t1;
         f2_fm_ff <= fm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) f3_vld_ff <= 1'b0;
      else if (en) f3_vld_ff <= f2_vld_ff;
      if (en) begin
         f3_lrx_ff  <= $signed({1'b0, cfg.lr}) * $signed(f2_x_ff);
         f3_c2g2_ff <= 57'(c2coef) * 57'(f2_g2_ff);
         f3_p_ff    <= f2_p_ff;
         f3_g_ff    <= f2_g_ff;
         f3_m_ff    <= f2_m_ff;
         f3_v_ff    <= f2_v_ff;
         f3_t1_ff   <= f2_t1_ff;
         f3_fm_ff   <= f2_fm_ff;
      end
   end

   always_comb begin
      step  = 34'((f3_lrx_ff + 58'sd8388608) >>> FRAC_W);
      pdiff = 35'($signed(f3_p_ff)) - 35'(step);
      fp    = 1'b0;
      if (pdiff > 35'sd2147483647) begin
         p01 = SMAX;
         fp  = 1'b1;
      end else if (pdiff < -35'sd2147483648) begin
         p01 = SMIN;
         fp  = 1'b1;
      end else begin
         p01 = pdiff[DATA_W-1:0];
      end
      t2   = 42'((58'(f3_c2g2_ff) + 58'd32768) >> 16);
      vsum = 43'(f3_t1_ff) + 43'(t2);
      fv   = |vsum[42:DATA_W];
      v_new = fv ? UMAX : vsum[DATA_W-1:0];
      slow_mode = (cfg.mode == MODE_RMSPROP) || (cfg.mode == MODE_ADAM);
      out_item.p    = f3_p_ff;
      out_item.g    = f3_g_ff;
      out_item.m    = f3_m_ff;
      out_item.v    = slow_mode ? v_new : f3_v_ff;
      out_item.p01  = p01;
      out_item.flag = f3_fm_ff | (slow_mode ? fv : fp);
   end

endmodule

/* hdl/gou_fifo.sv */
// gou_fifo: short item queue between front and back.
// Depends on gou_pkg.
module gou_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  gou_pkg::fq_type push_item,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output gou_pkg::fq_type pop_item
);
   import gou_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   fq_type           mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign valid    = (count_ff != '0);
   assign full     = (count_ff == (PTR_W+1)'(FIFO_DEPTH));
   assign pop_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

/* hdl/gou_divider.sv */
// gou_divider: pipelined restoring divider, one quotient bit per stage, with side payload.
// Depends on no other file.
module gou_divider #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 33,
   parameter int PAY_W = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   input  logic [PAY_W-1:0] pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] quo,
   output logic [PAY_W-1:0] pay_out
);
   logic             vld_ff [1:NUM_W];
   logic [DEN_W-1:0] rem_ff [1:NUM_W];
   logic [NUM_W-1:0] q_ff   [1:NUM_W];
   logic [DEN_W-1:0] den_ff [1:NUM_W];
   logic [PAY_W-1:0] pay_ff [1:NUM_W];

   for (genvar i = 0; i < NUM_W; i++) begin : g_stage
      logic             vld_src;
      logic [DEN_W-1:0] rem_src, den_src;
      logic [NUM_W-1:0] q_src;
      logic [PAY_W-1:0] pay_src;
      logic [DEN_W:0]   trial;
      logic             take;
      if (i == 0) begin : g_first
         assign vld_src = in_valid;
         assign rem_src = '0;
         assign q_src   = num;
         assign den_src = den;
         assign pay_src = pay;
      end else begin : g_next
         assign vld_src = vld_ff[i];
         assign rem_src = rem_ff[i];
         assign q_src   = q_ff[i];
         assign den_src = den_ff[i];
         assign pay_src = pay_ff[i];
      end
      assign trial = {rem_src, q_src[NUM_W-1]};
      assign take  = (trial >= {1'b0, den_src});
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else if (en) vld_ff[i+1] <= vld_src;
         if (en) begin
            rem_ff[i+1] <= take ? DEN_W'(trial - {1'b0, den_src}) : trial[DEN_W-1:0];
            q_ff[i+1]   <= {q_src[NUM_W-2:0], take};
            den_ff[i+1] <= den_src;
            pay_ff[i+1] <= pay_src;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W];
   assign quo       = q_ff[NUM_W];
   assign pay_out   = pay_ff[NUM_W];

endmodule

/* hdl/gou_sqrt.sv */
// gou_sqrt: pipelined floor square root, one root bit per stage, with side payload.
// Depends on no other file.
module gou_sqrt #(
   parameter int IN_W  = 56,
   parameter int PAY_W = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [IN_W-1:0]     radicand,
   input  logic [PAY_W-1:0]    pay,
   output logic                out_valid,
   output logic [IN_W/2-1:0]   root,
   output logic [PAY_W-1:0]    pay_out
);
   localparam int RW    = IN_W / 2;
   localparam int REM_W = RW + 2;

   logic             vld_ff  [1:RW];
   logic [REM_W-1:0] rem_ff  [1:RW];
   logic [RW-1:0]    root_ff [1:RW];
   logic [IN_W-1:0]  x_ff    [1:RW];
   logic [PAY_W-1:0] pay_ff  [1:RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      logic             vld_src;
      logic [REM_W-1:0] rem_src;
      logic [RW-1:0]    root_src;
      logic [IN_W-1:0]  x_src;
      logic [PAY_W-1:0] pay_src;
      logic [REM_W+1:0] rem_t, trial;
      logic             take;
      if (i == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = '0;
         assign root_src = '0;
         assign x_src    = radicand;
         assign pay_src  = pay;
      end else begin : g_next
         assign vld_src  = vld_ff[i];
         assign rem_src  = rem_ff[i];
         assign root_src = root_ff[i];
         assign x_src    = x_ff[i];
         assign pay_src  = pay_ff[i];
      end
      assign rem_t = {rem_src, x_src[IN_W-1 -: 2]};
      assign trial = (REM_W+2)'({root_src, 2'b01});
      assign take  = (rem_t >= trial);
      always_ff @(posedge clock) begin
         if (reset) vld_ff[i+1] <= 1'b0;
         else if (en) vld_ff[i+1] <= vld_src;
         if (en) begin
            rem_ff[i+1]  <= take ? REM_W'(rem_t - trial) : REM_W'(rem_t);
            root_ff[i+1] <= {root_src[RW-2:0], take};
            x_ff[i+1]    <= {x_src[IN_W-3:0], 2'b00};
            pay_ff[i+1]  <= pay_src;
         end
      end
   end

   assign out_valid = vld_ff[RW];
   assign root      = root_ff[RW];
   assign pay_out   = pay_ff[RW];

endmodule

/* hdl/gou_back.sv */
// gou_back: Adam bias correction, root and scaled step, and the result register.
// Depends on gou_pkg, gou_divider and gou_sqrt.
module gou_back (
   input  logic                        clock,
   input  logic                        reset,
   input  gou_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   input  gou_pkg::fq_type             in_item,
   output logic                        pop,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [gou_pkg::DATA_W-1:0]  out_param,
   output logic [gou_pkg::DATA_W-1:0]  out_m,
   output logic [gou_pkg::DATA_W-1:0]  out_v,
   output logic                        out_sat
);
   import gou_pkg::*;

   localparam int NUM_A = 2 * DATA_W;
   localparam int MAG_W = LR_W + DATA_W - 1;
   localparam int PRD_W = MAG_W + 2;
   localparam int RAD_W = DATA_W + FRAC_W;
   localparam int RT_W  = RAD_W / 2;
   localparam int D_W   = RT_W + 1;

   typedef struct packed {
      logic [DATA_W-1:0] p, g, m, p01;
      logic              flag;
   } pa_type;

   typedef struct packed {
      logic [PRD_W-1:0]  num;
      logic [DATA_W-1:0] p, m, v, p01;
      logic              flag;
   } sp_type;

   typedef struct packed {
      logic              neg, nz, dz;
      logic [DATA_W-1:0] p, m, v, p01;
      logic              flag;
   } dc_type;

   logic en;
   logic [DATA_W-1:0] mabs;
   pa_type            pa_in, pa_q;
   logic              da_vld, db_vld;
   logic [NUM_A-1:0]  qa, qb;
   logic [DATA_W-1:0] vq;

   logic              post_vld_ff;
   sp_type            post_ff, post_in;
   logic [DATA_W-1:0] r2_ff, r2_in;
   logic [DATA_W-1:0] mh, vh, xsel;
   logic              sm, sv, adam;

   logic              sq_vld;
   logic [RT_W-1:0]   root;
   logic [$bits(sp_type)-1:0] sq_pay;
   sp_type            sq_q;
   dc_type            dc_in, dc_q;
   logic [D_W-1:0]    dsum;
   logic [MAG_W-1:0]  nmag, mag;
   logic              dc_vld;
   logic [$bits(dc_type)-1:0] dc_pay;

   logic              rsp_vld_ff;
   logic [DATA_W-1:0] param_ff, param_in, m_ff, v_ff;
   logic              sat_ff, sat_in;
   logic signed [PRD_W-1:0] psum;

   // the whole back end advances together with the result register
   assign en  = ~rsp_vld_ff | out_ready;
   assign pop = in_valid & en;

   assign mabs = in_item.m[DATA_W-1] ? (~in_item.m + 32'd1) : in_item.m;
   assign pa_in.p    = in_item.p;
   assign pa_in.g    = in_item.g;
   assign pa_in.m    = in_item.m;
   assign pa_in.p01  = in_item.p01;
   assign pa_in.flag = in_item.flag;

   gou_divider #(.NUM_W(NUM_A), .DEN_W(CORR_W), .PAY_W($bits(pa_type))) u_div_m (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid),
      .num({mabs, {DATA_W{1'b0}}}), .den(cfg.corr1), .pay(pa_in),
      .out_valid(da_vld), .quo(qa), .pay_out(pa_q)
   );

   gou_divider #(.NUM_W(NUM_A), .DEN_W(CORR_W), .PAY_W(DATA_W)) u_div_v (
      .clock(clock), .reset(reset), .en(en), .in_valid(in_valid),
      .num({in_item.v, {DATA_W{1'b0}}}), .den(cfg.corr2), .pay(in_item.v),
      .out_valid(db_vld), .quo(qb), .pay_out(vq)
   );

   // saturate the corrected moments and form lr * step numerator
   always_comb begin
      sm = 1'b0;
      sv = 1'b0;
      if (pa_q.m[DATA_W-1]) begin
         if (qa > NUM_A'(SMIN)) begin
            sm = 1'b1;
            mh = SMIN;
         end else begin
            mh = DATA_W'(~qa + 1'b1);
         end
      end else if (qa > NUM_A'(SMAX)) begin
         sm = 1'b1;
         mh = SMAX;
      end else begin
         mh = qa[DATA_W-1:0];
      end
      if (|qb[NUM_A-1:DATA_W]) begin
         sv = 1'b1;
         vh = UMAX;
      end else begin
         vh = qb[DATA_W-1:0];
      end
      adam          = (cfg.mode == MODE_ADAM);
      xsel          = adam ? mh : pa_q.g;
      r2_in         = adam ? vh : vq;
      post_in.num   = $signed({1'b0, cfg.lr}) * $signed(xsel);
      post_in.p     = pa_q.p;
      post_in.m     = pa_q.m;
      post_in.v     = vq;
      post_in.p01   = pa_q.p01;
      post_in.flag  = pa_q.flag | (adam & (sm | sv));
   end

   always_ff @(posedge clock) begin
      if (reset) post_vld_ff <= 1'b0;
      else if (en) post_vld_ff <= da_vld & db_vld;
      if (en) begin
         post_ff <= post_in;
         r2_ff   <= r2_in;
      end
   end

   gou_sqrt #(.IN_W(RAD_W), .PAY_W($bits(sp_type))) u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(post_vld_ff),
      .radicand({r2_ff, {FRAC_W{1'b0}}}), .pay(post_ff),
      .out_valid(sq_vld), .root(root), .pay_out(sq_pay)
   );

   always_comb begin
      sq_q       = sp_type'(sq_pay);
      dsum       = D_W'(root) + D_W'(cfg.eps);
      nmag       = sq_q.num[PRD_W-1] ? MAG_W'(-sq_q.num) : MAG_W'(sq_q.num);
      dc_in.neg  = sq_q.num[PRD_W-1];
      dc_in.nz   = (sq_q.num == '0);
      dc_in.dz   = (dsum == '0);
      dc_in.p    = sq_q.p;
      dc_in.m    = sq_q.m;
      dc_in.v    = sq_q.v;
      dc_in.p01  = sq_q.p01;
      dc_in.flag = sq_q.flag;
   end

   gou_divider #(.NUM_W(MAG_W), .DEN_W(D_W), .PAY_W($bits(dc_type))) u_div_step (
      .clock(clock), .reset(reset), .en(en), .in_valid(sq_vld),
      .num(nmag), .den(dsum), .pay(dc_in),
      .out_valid(dc_vld), .quo(mag), .pay_out(dc_pay)
   );

   always_comb begin
      dc_q     = dc_type'(dc_pay);
      param_in = dc_q.p01;
      sat_in   = dc_q.flag;
      psum     = '0;
      if (cfg.mode == MODE_RMSPROP || cfg.mode == MODE_ADAM) begin
         if (dc_q.nz) begin
            param_in = dc_q.p;
         end else if (dc_q.dz) begin
            // zero divisor: clip opposite the numerator's sign
            sat_in   = 1'b1;
            param_in = dc_q.neg ? SMAX : SMIN;
         end else begin
            if (dc_q.neg) psum = PRD_W'($signed(dc_q.p)) + $signed({2'b00, mag});
            else          psum = PRD_W'($signed(dc_q.p)) - $signed({2'b00, mag});
            if (psum > PRD_W'($signed(SMAX))) begin
               sat_in   = 1'b1;
               param_in = SMAX;
            end else if (psum < PRD_W'($signed(SMIN))) begin
               sat_in   = 1'b1;
               param_in = SMIN;
            end else begin
               param_in = psum[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (en) rsp_vld_ff <= dc_vld;
      if (en) begin
         param_ff <= param_in;
         m_ff     <= dc_q.m;
         v_ff     <= dc_q.v;
         sat_ff   <= sat_in;
      end
   end

   assign out_valid = rsp_vld_ff;
   assign out_param = param_ff;
   assign out_m     = m_ff;
   assign out_v     = v_ff;
   assign out_sat   = sat_ff;

endmodule

/* hdl/gradient_optimizer_update_core.sv */
// gradient_optimizer_update_core: top level of the optimizer update block.
// Depends on gou_pkg, gou_csr, gou_front, gou_fifo, gou_back.
//
//   channel   direction  handshake               content
//   req_*     in         tvalid/tready           param, gradient, first and second moment
//   rsp_*     out        tvalid/tready           param_out, new moments; tuser = saturated
//   csr_*     in         APB, pready tied high   six configuration registers
//
// One item per cycle sustained while rsp_tready stays high and the sequencer is idle. On its way
// to rsp_tvalid an accepted item passes 3 front stages, the queue, the two parallel 64-stage
// dividers, one register, the 28-stage root pipeline, the 56-stage divider and the result register.
// After reset, and after any write to momentum_coeff, decay_rate or step_count,
// req_tready stays low while the bias correction sequencer runs.
// A stalled rsp side freezes the whole back end; the four-entry queue and the three
// front stages then take at most seven more items before req_tready drops.
module gradient_optimizer_update_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [127:0]                req_tdata,   // param_in, gradient, first_moment, second_moment
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [95:0]                 rsp_tdata,   // param_out, new_first_moment, new_second_moment
   output logic                        rsp_tuser,   // saturated
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [gou_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);
   import gou_pkg::*;

   cfg_type cfg;
   logic    busy;
   logic    front_ready, push, full, pop, fifo_valid;
   fq_type  front_item, fifo_item;
   logic [DATA_W-1:0] out_param, out_m, out_v;

   gou_csr u_csr (
      .clock(clock), .reset(reset),
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .cfg(cfg), .busy(busy)
   );

   assign req_tready = front_ready & ~busy;

   gou_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(req_tvalid & ~busy), .in_ready(front_ready),
      .in_p(req_tdata[31:0]), .in_g(req_tdata[63:32]),
      .in_m(req_tdata[95:64]), .in_v(req_tdata[127:96]),
      .push(push), .full(full), .out_item(front_item)
   );

   gou_fifo u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_item(front_item), .full(full),
      .pop(pop), .valid(fifo_valid), .pop_item(fifo_item)
   );

   gou_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .in_valid(fifo_valid), .in_item(fifo_item), .pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_param(out_param), .out_m(out_m), .out_v(out_v), .out_sat(rsp_tuser)
   );

   assign rsp_tdata = {out_v, out_m, out_param};

endmodule
